// ----- rtl/core/lsm_pkg.sv -----
// shared types and constants for the literal substring matcher
`timescale 1ns / 1ps

package lsm_pkg;

    // defaults for the top-level parameters
    localparam int MAX_NEEDLE_DEF  = 32;
    localparam int POS_BITS_DEF    = 24;
    localparam int Q_DEPTH_DEF     = 4;

    // needle storage: four 64-bit registers, eight characters each
    localparam int NEEDLE_REGS     = 4;
    localparam int CFG_DATA_W      = 64;
    localparam int NEEDLE_CHARS    = NEEDLE_REGS * CFG_DATA_W / 8;
    localparam int NEEDLE_BITS     = NEEDLE_REGS * CFG_DATA_W;
    localparam int LEN_W           = 6;

    localparam int CFG_IDX_W       = 3;

    // width of the start and total fields in a result
    localparam int FIELD_W         = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_0   = 3'd0,
        CFG_NEEDLE_1   = 3'd1,
        CFG_NEEDLE_2   = 3'd2,
        CFG_NEEDLE_3   = 3'd3,
        CFG_NEEDLE_LEN = 3'd4,
        CFG_CASE_SENS  = 3'd5,
        CFG_WHOLE_WORD = 3'd6
    } t_cfg_idx;

    // results caused by one text byte, as handed from front to back
    typedef struct packed {
        logic               pend_v;
        logic [FIELD_W-1:0] pend_start;
        logic               hit_v;
        logic [FIELD_W-1:0] hit_start;
        logic               eot;
        logic [FIELD_W-1:0] total;
    } t_rec;

endpackage

// ----- rtl/core/lsm_front.sv -----
// front end: config registers, text window, compare and match decisions
`timescale 1ns / 1ps

module lsm_front import lsm_pkg::*; #(
    parameter int MAX_NEEDLE    = MAX_NEEDLE_DEF,
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    input  logic                  i_eot,
    input  logic                  i_room,
    output logic                  o_ready,
    output logic                  o_push,
    output t_rec                  o_rec,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int P   = POSITION_BITS;
    localparam int NIW = $clog2(NEEDLE_CHARS);

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UNDERSC = 8'h5F;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
        if (!cs && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return c + CASE_DELTA;
        end
        return c;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) || c == CH_UNDERSC;
    endfunction

    function automatic logic [7:0] needle_byte(input logic [NEEDLE_BITS-1:0] nd,
                                               input logic [6:0] k);
        if (k < 7'(NEEDLE_CHARS)) begin
            return nd[{k[NIW-1:0], 3'b000} +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [P-1:0] v);
        logic [P+FIELD_W-1:0] wide;
        wide = (P + FIELD_W)'(v);
        return wide[FIELD_W-1:0];
    endfunction

    // configuration
    logic [NEEDLE_BITS-1:0] r_needle;
    logic [LEN_W-1:0]       r_len;
    logic                   r_cs;
    logic                   r_ww;

    // text state
    logic [7:0]   r_bytes [MAX_NEEDLE];
    logic [7:0]   n_bytes [MAX_NEEDLE];
    logic         r_flags [MAX_NEEDLE];
    logic         n_flags [MAX_NEEDLE+1];
    logic [P-1:0] r_pos;
    logic         r_pend_v;
    logic [P-1:0] r_pend_start;
    logic [P-1:0] r_cnt;

    logic         fire;
    logic         hit;
    logic         left_flag;
    logic         len_ok;
    logic         hit_ok;
    logic         pend_emit;
    logic         hit_emit;
    logic [P:0]   start_w;
    logic [P-1:0] start;
    logic [P-1:0] cnt1;
    logic [P-1:0] cnt2;
    logic [P-1:0] n_pos;
    logic [6:0]   k;

    assign o_ready = i_room;
    assign fire    = i_valid && i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle <= '0;
            r_len    <= '0;
            r_cs     <= 1'b1;
            r_ww     <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NEEDLE_0:   r_needle[0*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                CFG_NEEDLE_1:   r_needle[1*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                CFG_NEEDLE_2:   r_needle[2*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                CFG_NEEDLE_3:   r_needle[3*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                CFG_NEEDLE_LEN: r_len <= i_cfg_data[LEN_W-1:0];
                CFG_CASE_SENS:  r_cs  <= i_cfg_data[0];
                CFG_WHOLE_WORD: r_ww  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // shifted window, newest byte at index 0
    always_comb begin
        n_bytes[0] = i_byte;
        for (int j = 1; j < MAX_NEEDLE; j++) begin
            n_bytes[j] = r_bytes[j-1];
        end
        n_flags[0] = is_word(i_byte);
        for (int j = 1; j <= MAX_NEEDLE; j++) begin
            n_flags[j] = r_flags[j-1];
        end
    end

    // window position j lines up with needle character len-1-j
    always_comb begin
        hit       = 1'b1;
        left_flag = 1'b0;
        k         = '0;
        for (int j = 0; j < MAX_NEEDLE; j++) begin
            if (7'(j) < 7'(r_len)) begin
                k = 7'(r_len) - 7'(j) - 7'd1;
                if (fold(n_bytes[j], r_cs) != fold(needle_byte(r_needle, k), r_cs)) begin
                    hit = 1'b0;
                end
            end
        end
        for (int j = 1; j <= MAX_NEEDLE; j++) begin
            if (7'(j) == 7'(r_len)) begin
                left_flag = n_flags[j];
            end
        end
    end

    always_comb begin
        len_ok    = (r_len != '0) && (7'(r_len) <= 7'(MAX_NEEDLE)) &&
                    (({1'b0, r_pos} + (P+1)'(1)) >= (P+1)'(r_len));
        hit_ok    = len_ok && hit && (!r_ww || !left_flag);
        pend_emit = r_pend_v && (!r_ww || !n_flags[0]);
        hit_emit  = hit_ok && i_eot;
        start_w   = {1'b0, r_pos} + (P+1)'(1) - (P+1)'(r_len);
        start     = start_w[P-1:0];
        cnt1      = (pend_emit && r_cnt != '1) ? r_cnt + 1'b1 : r_cnt;
        cnt2      = (hit_emit && cnt1 != '1) ? cnt1 + 1'b1 : cnt1;
        n_pos     = (r_pos != '1) ? r_pos + 1'b1 : r_pos;
    end

    always_comb begin
        o_push           = fire && (pend_emit || i_eot);
        o_rec.pend_v     = pend_emit;
        o_rec.pend_start = to_field(r_pend_start);
        o_rec.hit_v      = hit_emit;
        o_rec.hit_start  = to_field(start);
        o_rec.eot        = i_eot;
        o_rec.total      = to_field(cnt2);
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int j = 0; j < MAX_NEEDLE; j++) begin
                r_bytes[j] <= n_bytes[j];
            end
            if (hit_ok && !i_eot) begin
                r_pend_start <= start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_NEEDLE; j++) begin
                r_flags[j] <= 1'b0;
            end
            r_pos    <= '0;
            r_pend_v <= 1'b0;
            r_cnt    <= '0;
        end else if (fire) begin
            // end of text puts the text state back to reset
            if (i_eot) begin
                for (int j = 0; j < MAX_NEEDLE; j++) begin
                    r_flags[j] <= 1'b0;
                end
                r_pos    <= '0;
                r_pend_v <= 1'b0;
                r_cnt    <= '0;
            end else begin
                for (int j = 0; j < MAX_NEEDLE; j++) begin
                    r_flags[j] <= n_flags[j];
                end
                r_pos    <= n_pos;
                r_pend_v <= hit_ok;
                r_cnt    <= cnt2;
            end
        end
    end

endmodule

// ----- rtl/core/lsm_queue.sv -----
// short register queue of result records between front and back
`timescale 1ns / 1ps

module lsm_queue import lsm_pkg::*; #(
    parameter int DEPTH = Q_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_rec o_rec
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/core/lsm_back.sv -----
// back end: unpacks each record into its results, one transaction per cycle while i_ready is high
`timescale 1ns / 1ps

module lsm_back import lsm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  t_rec                   i_q_rec,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2*FIELD_W-1:0]   o_data,
    output logic                   o_kind,
    output logic                   o_last
);

    localparam int L_PEND = 0;
    localparam int L_HIT  = 1;
    localparam int L_SUM  = 2;

    t_rec       r_rec;
    logic [2:0] r_left;
    logic [2:0] rest;
    logic       fire;
    logic       adv;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] total;

    // results still owed for the held record, lowest bit goes first
    assign rest    = r_left & (r_left - 3'd1);
    assign o_valid = (r_left != '0);
    assign o_last  = (rest == '0);
    assign fire    = o_valid && i_ready;
    assign adv     = !o_valid || (fire && o_last);
    assign o_q_pop = adv && i_q_valid;

    always_comb begin
        o_kind = r_left[L_SUM] && !r_left[L_PEND] && !r_left[L_HIT];
        start  = r_left[L_PEND] ? r_rec.pend_start :
                 r_left[L_HIT]  ? r_rec.hit_start  : '0;
        total  = o_kind ? r_rec.total : '0;
        o_data = {total, start};
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_q_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (adv) begin
            r_left <= i_q_valid ? {i_q_rec.eot, i_q_rec.hit_v, i_q_rec.pend_v} : 3'b000;
        end else if (fire) begin
            r_left <= rest;
        end
    end

endmodule

// ----- rtl/core/literal_substring_matcher.sv -----
// top level of the literal substring matcher
//
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tdata[7:0] text_byte, tlast end_of_text
//  m_axis    out  m_axis_tvalid/tready   tdata[23:0] match_start, [47:24] match_total,
//                                        tuser item_kind, tlast last_in_run
//  cfg       in   i_cfg_we               i_cfg_idx register index, i_cfg_data value
//
// one text byte is taken per cycle; s_axis_tready drops only when the queue is full.
// the window compare against the needle is combinational. results leave at one
// per cycle from the back end if m_axis_tready is high, so a byte that causes two or
// three results uses the queue (Q_DEPTH records) to absorb the extra cycles. reset is
// synchronous, active low, and the block is ready in the first cycle after it.
`timescale 1ns / 1ps

module literal_substring_matcher import lsm_pkg::*; #(
    parameter int MAX_NEEDLE    = MAX_NEEDLE_DEF,
    parameter int POSITION_BITS = POS_BITS_DEF,
    parameter int Q_DEPTH       = Q_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // text_byte
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [2*FIELD_W-1:0]  m_axis_tdata,   // match_start, match_total
    output logic                  m_axis_tuser,   // item_kind
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_rec push_rec;
    t_rec head_rec;

    lsm_front #(
        .MAX_NEEDLE    (MAX_NEEDLE),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_byte     (s_axis_tdata),
        .i_eot      (s_axis_tlast),
        .i_room     (!q_full),
        .o_ready    (s_axis_tready),
        .o_push     (q_push),
        .o_rec      (push_rec),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    lsm_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (head_rec)
    );

    lsm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_rec   (head_rec),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_kind    (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

    // a summary always closes the run of its byte
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("summary transaction without tlast");

    // a match carries no total
    a_match_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[2*FIELD_W-1:FIELD_W] == '0)
        else $error("match transaction with nonzero total");

    // the queue is never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("queue written while full");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

// ----- tb/tb_literal_substring_matcher.sv -----
// self-checking testbench for the literal substring matcher
`timescale 1ns / 1ps

module tb_literal_substring_matcher;
    import lsm_pkg::*;

    localparam int WIN   = MAX_NEEDLE_DEF;
    localparam int LIMIT = 200000;

    typedef struct packed {
        logic               kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] total;
        logic               last;
    } t_exp_item;

    class match_scoreboard;
        logic [CFG_DATA_W-1:0] needle_reg[NEEDLE_REGS];
        logic [LEN_W-1:0]      needle_len;
        logic                  case_exact;
        logic                  whole_word;
        logic [7:0]            window[WIN];
        logic                  word_flag[WIN+1];
        logic [FIELD_W-1:0]    pos;
        logic                  pend_v;
        logic [FIELD_W-1:0]    pend_start;
        logic [FIELD_W-1:0]    hit_count;
        t_exp_item             due_items[$];
        int                    mismatches;

        function new();
            foreach (needle_reg[r]) needle_reg[r] = '0;
            needle_len = '0;
            case_exact = 1'b1;
            whole_word = 1'b0;
            mismatches = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (window[k]) window[k] = '0;
            foreach (word_flag[k]) word_flag[k] = 1'b0;
            pos        = '0;
            pend_v     = 1'b0;
            pend_start = '0;
            hit_count  = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_NEEDLE_0:   needle_reg[0] = v;
                CFG_NEEDLE_1:   needle_reg[1] = v;
                CFG_NEEDLE_2:   needle_reg[2] = v;
                CFG_NEEDLE_3:   needle_reg[3] = v;
                CFG_NEEDLE_LEN: needle_len = v[LEN_W-1:0];
                CFG_CASE_SENS:  case_exact = v[0];
                CFG_WHOLE_WORD: whole_word = v[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] fold(logic [7:0] c);
            if (!case_exact && c >= "A" && c <= "Z") return c + 8'd32;
            return c;
        endfunction

        function logic is_ident(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                   (c >= "0" && c <= "9") || c == "_";
        endfunction

        function logic [7:0] needle_char(int k);
            if (k >= NEEDLE_CHARS) return 8'h00;
            return needle_reg[k / 8][(k % 8) * 8 +: 8];
        endfunction

        function void push_item(logic kind, logic [FIELD_W-1:0] st, logic [FIELD_W-1:0] tot);
            t_exp_item r;
            r.kind  = kind;
            r.start = st;
            r.total = tot;
            r.last  = 1'b0;
            due_items.insert(due_items.size(), r);
        endfunction

        function void push_match(logic [FIELD_W-1:0] st);
            if (hit_count != '1) hit_count++;
            push_item(1'b0, st, '0);
        endfunction

        // predicts the results of one accepted text byte
        function void note_text_byte(logic [7:0] b, logic eot);
            int         len;
            int         n0;
            int         k;
            logic       hit;
            t_exp_item  r;
            len = int'(needle_len);
            n0  = due_items.size();
            for (k = WIN - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = b;
            for (k = WIN; k > 0; k--) word_flag[k] = word_flag[k-1];
            word_flag[0] = is_ident(b);

            // right-side check of the match ending on the previous byte
            if (pend_v) begin
                if (!whole_word || !word_flag[0]) push_match(pend_start);
                pend_v = 1'b0;
            end

            if (len >= 1 && len <= WIN && int'(pos) + 1 >= len) begin
                hit = 1'b1;
                for (k = 0; k < len; k++)
                    if (fold(window[len-1-k]) != fold(needle_char(k))) hit = 1'b0;
                if (hit && (!whole_word || !word_flag[len])) begin
                    if (eot) begin
                        push_match(FIELD_W'(pos + 1 - len));
                    end else begin
                        pend_v     = 1'b1;
                        pend_start = FIELD_W'(pos + 1 - len);
                    end
                end
            end

            if (pos != '1) pos++;

            if (eot) begin
                push_item(1'b1, '0, hit_count);
                clear_text();
            end

            if (due_items.size() > n0) begin
                r = due_items[due_items.size() - 1];
                r.last = 1'b1;
                due_items[due_items.size() - 1] = r;
            end
        endfunction

        function void compare_field(string name, logic [FIELD_W-1:0] want,
                                    logic [FIELD_W-1:0] got);
            if (got !== want) begin
                $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic kind, logic [FIELD_W-1:0] st,
                                   logic [FIELD_W-1:0] tot, logic last);
            t_exp_item w;
            if (due_items.size() == 0) begin
                $display("%0t ns: result with none expected, actual kind %0d start %0d total %0d",
                         $time, kind, st, tot);
                mismatches++;
                return;
            end
            w = due_items.pop_front();
            compare_field("item_kind", FIELD_W'(w.kind), FIELD_W'(kind));
            compare_field("match_start", w.start, st);
            compare_field("match_total", w.total, tot);
            compare_field("last_in_run", FIELD_W'(w.last), FIELD_W'(last));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;    // text_byte
    logic                  s_axis_tlast = 1'b0;  // end_of_text
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [2*FIELD_W-1:0]  m_axis_tdata;         // match_start, match_total
    logic                  m_axis_tuser;         // item_kind
    logic                  m_axis_tlast;         // last_in_run
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    match_scoreboard sb = new();

    logic [7:0] needle_buf[NEEDLE_CHARS];
    int         cur_len;
    int         tx_idle_pct = 18;
    int         rx_idle_pct = 49;
    logic       hold_req = 1'b0;
    int         bytes_sent = 0;
    int         cycles = 0;

    literal_substring_matcher u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // result side: check every transaction, random stalls plus one long hold-off
    initial begin : result_side
        int   hold_left;
        logic hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata[FIELD_W-1:0],
                                m_axis_tdata[2*FIELD_W-1:FIELD_W], m_axis_tlast);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_text_byte(b, eot);
        bytes_sent++;
    endtask

    task automatic send_str(input string s, input logic end_text);
        int k;
        for (k = 0; k < s.len(); k++) send_byte(s[k], end_text && k == s.len() - 1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_items.size() != 0) @(posedge i_clk);
    endtask

    // idle before a register write: results drained, pipeline given time to empty
    task automatic settle();
        drain();
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    function automatic logic [CFG_DATA_W-1:0] needle_word(int r);
        logic [CFG_DATA_W-1:0] w;
        for (int k = 0; k < 8; k++) w[k*8 +: 8] = needle_buf[r*8 + k];
        return w;
    endfunction

    task automatic load_setting(input int len, input logic exact, input logic ww,
                                input logic junk_high);
        logic [CFG_DATA_W-1:0] hi;
        hi = junk_high ? {$urandom, $urandom} : '0;
        cur_len = len;
        write_reg(CFG_NEEDLE_0, needle_word(0));
        write_reg(CFG_NEEDLE_1, needle_word(1));
        write_reg(CFG_NEEDLE_2, needle_word(2));
        write_reg(CFG_NEEDLE_3, needle_word(3));
        write_reg(CFG_NEEDLE_LEN, {hi[CFG_DATA_W-1:LEN_W], 6'(len)});
        write_reg(CFG_CASE_SENS, {hi[CFG_DATA_W-1:1], exact});
        write_reg(CFG_WHOLE_WORD, {hi[CFG_DATA_W-1:1], ww});
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_needle_str(input string s, input logic [7:0] fill);
        for (int k = 0; k < NEEDLE_CHARS; k++) needle_buf[k] = (k < s.len()) ? s[k] : fill;
    endtask

    function automatic logic [7:0] flip_case(logic [7:0] c);
        if (((c | 8'h20) >= "a") && ((c | 8'h20) <= "z") && $urandom_range(1))
            return c ^ 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] needle_alpha();
        case ($urandom_range(5))
            0: return "a";
            1: return "b";
            2: return "A";
            3: return "_";
            4: return "1";
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] separator();
        case ($urandom_range(4))
            0: return " ";
            1: return ".";
            2: return "-";
            3: return 8'h00;
            default: return 8'hFF;
        endcase
    endfunction

    // needle copies and partial copies mixed with word and non-word bytes; some texts pure noise
    task automatic send_text(input int target);
        logic [7:0] txt[$];
        int         k;
        int         pick;
        int         nl;
        logic       noise;
        nl    = (cur_len >= 1 && cur_len <= WIN) ? cur_len : 3;
        noise = ($urandom_range(99) < 20);
        while (txt.size() < target) begin
            pick = noise ? 99 : $urandom_range(99);
            if (pick < 30) begin
                for (k = 0; k < nl; k++) txt.insert(txt.size(), flip_case(needle_buf[k]));
            end else if (pick < 38) begin
                for (k = 0; k < $urandom_range(nl - 1); k++)
                    txt.insert(txt.size(), flip_case(needle_buf[k]));
            end else if (pick < 58) begin
                txt.insert(txt.size(), separator());
            end else if (pick < 80) begin
                txt.insert(txt.size(), flip_case(needle_alpha()));
            end else begin
                txt.insert(txt.size(), 8'($urandom_range(255)));
            end
        end
        for (k = 0; k < txt.size(); k++) send_byte(txt[k], k == txt.size() - 1);
    endtask

    task automatic pick_random_needle();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)      cur_len = $urandom_range(1, 4);
        else if (sel < 75) cur_len = $urandom_range(5, 8);
        else if (sel < 83) cur_len = WIN;
        else if (sel < 88) cur_len = 0;
        else if (sel < 93) cur_len = $urandom_range(WIN + 1, 63);
        else               cur_len = $urandom_range(9, WIN - 1);
        for (int k = 0; k < NEEDLE_CHARS; k++)
            needle_buf[k] = (k < cur_len) ? needle_alpha() : 8'($urandom_range(255));
    endtask

    initial begin : stimulus
        int   first;
        int   tlen;
        logic paused;
        paused = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // overlapping hits, three results from one byte, extreme byte values
        set_needle_str("aa", 8'h00);
        load_setting(2, 1'b1, 1'b0, 1'b0);
        send_str("aaa", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        // case folding with whole-word boundaries, text end as right boundary
        settle();
        set_needle_str("Ab", 8'hFF);
        load_setting(2, 1'b0, 1'b1, 1'b0);
        send_str(" aB_ab aB", 1'b1);

        // one-byte text that is a whole-word match
        settle();
        set_needle_str("x", 8'h00);
        load_setting(1, 1'b1, 1'b1, 1'b0);
        send_str("x", 1'b1);

        // empty needle
        settle();
        set_needle_str("aa", 8'h00);
        load_setting(0, 1'b1, 1'b0, 1'b0);
        send_str("aa", 1'b1);

        // needle longer than the window, all-ones needle registers
        settle();
        set_needle_str("", 8'hFF);
        load_setting(WIN + 8, 1'b1, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1);

        // whole-word turned on while a match waits for its right side
        settle();
        set_needle_str("q", 8'h00);
        load_setting(1, 1'b1, 1'b0, 1'b0);
        send_byte("q", 1'b0);
        settle();
        load_setting(1, 1'b1, 1'b1, 1'b0);
        send_byte("r", 1'b1);

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 49 : 0;
            rx_idle_pct <= (ph == 0) ? 49 : (ph == 1) ? 18 : 0;
            for (int s = 0; s < 2; s++) begin
                settle();
                pick_random_needle();
                if (ph == 0 && s == 0) begin
                    // dense single-byte hits while the result side holds off
                    cur_len = 1;
                    needle_buf[0] = "a";
                    load_setting(1, 1'b0, 1'b0, 1'b1);
                    hold_req <= 1'b1;
                end else begin
                    load_setting(cur_len, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
                end
                first = bytes_sent;
                while (bytes_sent - first < 22) begin
                    tlen = (cur_len == WIN) ? WIN + $urandom_range(30) : $urandom_range(1, 24);
                    send_text(tlen);
                    if (ph == 1 && !paused && bytes_sent - first > 15) begin
                        drain();
                        paused = 1'b1;
                    end
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.due_items.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived, expected kind %0d start %0d",
                     $time, sb.due_items.size(), sb.due_items[0].kind, sb.due_items[0].start);
            sb.mismatches++;
        end
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
